// ----- rtl/esof_pkg.sv -----
// shared types for the encoder sigma outlier filter
package esof_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DRAIN,
		ST_CALC,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/esof_if.sv -----
// valid/ready stream interfaces for raw samples and filtered results
interface esof_in_if #(parameter int SAMPLE_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface esof_out_if #(parameter int SAMPLE_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] filtered_value;
	logic                   was_outlier;

	modport source (output valid, output filtered_value, output was_outlier, input ready);
	modport sink (input valid, input filtered_value, input was_outlier, output ready);
endinterface

// ----- rtl/esof_rank.sv -----
// lane bank that ranks the streamed window entries and picks the median
module esof_rank import esof_pkg::*; #(
	parameter int WINDOW_LEN  = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                             clk,
	input  logic                             load,
	input  logic [$clog2(WINDOW_LEN)-1:0]    idx,
	input  logic [SAMPLE_BITS-1:0]           data,
	output logic [SAMPLE_BITS-1:0]           median
);

	localparam int IW = $clog2(WINDOW_LEN);
	localparam logic [IW-1:0] K_LO = IW'((WINDOW_LEN - 1) / 2);
	localparam logic [IW-1:0] K_HI = IW'(WINDOW_LEN / 2);

	logic [SAMPLE_BITS-1:0] lane_q [WINDOW_LEN];
	logic [IW-1:0]          rank_q [WINDOW_LEN];
	logic [IW-1:0]          below;
	logic [SAMPLE_BITS-1:0] lo_val;
	logic [SAMPLE_BITS-1:0] hi_val;
	logic [SAMPLE_BITS:0]   mid_sum;

	// earlier lanes that are not above the new entry (ties ranked by index)
	always_comb begin
		below = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (IW'(i) < idx && lane_q[i] <= data) begin
				below = below + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				if (IW'(i) == idx) begin
					lane_q[i] <= data;
					rank_q[i] <= below;
				end else if (IW'(i) < idx && data < lane_q[i]) begin
					rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
		end
	end

	// ranks form a permutation, so each select hits exactly one lane
	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			if (rank_q[i] == K_LO) begin
				lo_val = lo_val | lane_q[i];
			end
			if (rank_q[i] == K_HI) begin
				hi_val = hi_val | lane_q[i];
			end
		end
		mid_sum = {1'b0, lo_val} + {1'b0, hi_val};
	end

	assign median = mid_sum[SAMPLE_BITS:1];

endmodule

// ----- rtl/encoder_sigma_outlier_filter.sv -----
// encoder sample outlier filter: sliding window sigma test with median substitution
//
// raw carries one encoder sample per request; filt returns one result per
// request: the sample itself, or the window median with was_outlier set when
// the sample lies outside mean plus or minus one population deviation of the
// window that already includes it.
// the window lives in a single-port memory used as a ring; a request is
// written at accept, then the whole window is read back one entry a cycle
// to build the sum, the sum of squares and the ranks of the median lanes.
// requests are taken only in the idle state: after the read walk over the
// window memory, a drain step and a compute step, the result is registered
// and the block returns to idle before it accepts the next request.
// reset clears the state machine and the per-entry valid bits, so entries
// never written read as zero; no clearing pass is needed.
// a new request is taken while a finished result still waits; if the
// receiver stalls, the block holds its next result until the output
// register frees and accepts nothing further meanwhile.
module encoder_sigma_outlier_filter import esof_pkg::*; #(
	parameter int WINDOW_LEN  = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	esof_in_if.sink      raw,
	esof_out_if.source   filt
);

	localparam int IW  = $clog2(WINDOW_LEN);
	localparam int SW  = SAMPLE_BITS + IW;
	localparam int QW  = 2 * SAMPLE_BITS + IW;
	localparam int PW  = 2 * SW;
	localparam int SQW = 2 * SAMPLE_BITS;
	localparam logic [IW-1:0] LAST = IW'(WINDOW_LEN - 1);

	state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] mem [WINDOW_LEN];
	logic [WINDOW_LEN-1:0]  vld_q;
	logic [IW-1:0]          wptr_q;
	logic [IW-1:0]          cnt_q;

	logic                   take;
	logic                   rd_en;
	logic                   out_free;
	logic                   fin;

	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                   rd_ok_s1;
	logic [IW-1:0]          rd_idx_s1;
	logic                   rd_vld_s1;
	logic [SAMPLE_BITS-1:0] w;
	logic [SQW-1:0]         wsq;

	logic [SAMPLE_BITS-1:0] x_q;
	logic [SW-1:0]          s_q;
	logic [QW-1:0]          q_q;

	logic [SW-1:0]          nx;
	logic [SW-1:0]          dev;
	logic [SW-1:0]          dev_s1;
	logic [PW-1:0]          ss_s1;
	logic [PW-1:0]          nq_s1;
	logic [SAMPLE_BITS-1:0] med;
	logic [SAMPLE_BITS-1:0] med_s1;
	logic [PW-1:0]          lhs;
	logic [PW-1:0]          rhs;
	logic                   outl;

	logic                   out_vld_q;
	logic [SAMPLE_BITS-1:0] out_val_q;
	logic                   out_flag_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (raw.valid) state_d = ST_LOAD;
			ST_LOAD:  if (cnt_q == LAST) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_CALC;
			ST_CALC:  state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		out_free = !out_vld_q || filt.ready;
		take     = 1'b0;
		rd_en    = 1'b0;
		fin      = 1'b0;
		unique case (state_q)
			ST_IDLE:  take = raw.valid;
			ST_LOAD:  rd_en = 1'b1;
			ST_DRAIN: ;
			ST_CALC:  ;
			ST_DONE:  fin = out_free;
			default:  ;
		endcase
	end

	assign raw.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			vld_q     <= '0;
			wptr_q    <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (take) begin
				vld_q[wptr_q] <= 1'b1;
				wptr_q        <= (wptr_q == LAST) ? '0 : wptr_q + IW'(1);
				cnt_q         <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + IW'(1);
			end
			if (fin) begin
				out_vld_q <= 1'b1;
			end else if (filt.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// window memory, one write or one read a cycle
	always_ff @(posedge clk) begin
		if (take) begin
			mem[wptr_q] <= raw.sample;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[cnt_q];
			rd_ok_s1   <= vld_q[cnt_q];
			rd_idx_s1  <= cnt_q;
		end
	end

	// entries never written stand for the zeros left by reset
	assign w   = rd_ok_s1 ? rd_data_s1 : '0;
	assign wsq = SQW'(w) * SQW'(w);

	esof_rank #(
		.WINDOW_LEN  (WINDOW_LEN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_rank (
		.clk    (clk),
		.load   (rd_vld_s1),
		.idx    (rd_idx_s1),
		.data   (w),
		.median (med)
	);

	assign nx  = SW'(WINDOW_LEN) * SW'(x_q);
	assign dev = (nx >= s_q) ? (nx - s_q) : (s_q - nx);
	assign lhs = PW'(dev_s1) * PW'(dev_s1);
	assign rhs = nq_s1 - ss_s1;
	assign outl = lhs > rhs;

	always_ff @(posedge clk) begin
		if (take) begin
			x_q <= raw.sample;
			s_q <= '0;
			q_q <= '0;
		end else if (rd_vld_s1) begin
			s_q <= s_q + SW'(w);
			q_q <= q_q + QW'(wsq);
		end
		if (state_q == ST_CALC) begin
			dev_s1 <= dev;
			ss_s1  <= PW'(s_q) * PW'(s_q);
			nq_s1  <= PW'(q_q) * PW'(WINDOW_LEN);
			med_s1 <= med;
		end
		if (fin) begin
			out_val_q  <= outl ? med_s1 : x_q;
			out_flag_q <= outl;
		end
	end

	assign filt.valid          = out_vld_q;
	assign filt.filtered_value = out_val_q;
	assign filt.was_outlier    = out_flag_q;

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == ST_LOAD && cnt_q == '0))
		else $error("read walk did not start after accept");

	a_read_data_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_LOAD || state_q == ST_DRAIN))
		else $error("memory read data outside the window walk");

	a_hold_while_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_vld_q && !filt.ready) |=> (state_q == ST_DONE))
		else $error("result dropped while the output register was full");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> !(take && $past(state_q) == ST_LOAD))
		else $error("request taken during the window walk");

endmodule
